FILE: rtl/smrc_pkg.sv
// shared constants for the shutter motor relay controller
package smrc_pkg;

    // number of motor channels
    localparam int CHANNELS = 10;

    // width of the channel mask and relay fields
    localparam int MaskW = 10;

    // working width of per-channel vectors, at least as wide as the fields
    localparam int BitsW = (CHANNELS > MaskW) ? CHANNELS : MaskW;

    // counter and register widths
    localparam int RunW   = 16;
    localparam int GuardW = 12;
    localparam int TickW  = 8;
    localparam int CountW = 4;
    localparam int OpW    = 2;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    // operation codes
    localparam logic [OpW-1:0] OP_TICK = 2'd0;
    localparam logic [OpW-1:0] OP_UP   = 2'd1;
    localparam logic [OpW-1:0] OP_DOWN = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_RUN_TIME_LONG  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RUN_TIME_SHORT = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LONG_MASK      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GUARD_TICKS    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_STAGGER_STEP   = 3'd4;

    // configuration reset values
    localparam logic [RunW-1:0]  RST_RUN_TIME_LONG  = 16'd3500;
    localparam logic [RunW-1:0]  RST_RUN_TIME_SHORT = 16'd2500;
    localparam logic [MaskW-1:0] RST_LONG_MASK      = 10'd49;
    localparam logic [TickW-1:0] RST_GUARD_TICKS    = 8'd30;
    localparam logic [TickW-1:0] RST_STAGGER_STEP   = 8'd20;

endpackage

FILE: rtl/shutter_motor_relay_control.sv
// top level of the shutter motor relay controller
//
// Drives a power relay and a direction relay per roller-shutter channel. Each
// item is a tick (advance every channel) or an up/down command for the channels
// set in i_channel_mask; the k-th selected channel in ascending order gets a
// start delay of k times the stagger step. Every item gives one result: the
// relay masks after that item. An item goes through an input register, then
// one pass of per-channel update logic into the channel state, which is also
// the result register; one item can be taken every cycle while the result
// side is not stalled. Configuration writes through the plain write port take
// effect on the next item and are meant for when the block is idle.
module shutter_motor_relay_control (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [smrc_pkg::OpW-1:0]         i_operation,
    input  logic [smrc_pkg::MaskW-1:0]       i_channel_mask,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [smrc_pkg::MaskW-1:0]       o_power_mask,
    output logic [smrc_pkg::MaskW-1:0]       o_direction_mask,
    input  logic                             i_cfg_we,
    input  logic [smrc_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [smrc_pkg::CfgDataW-1:0]    i_cfg_data
);

    // channel modes
    typedef enum logic [2:0] {
        MODE_UP_START   = 3'd0,
        MODE_UP         = 3'd1,
        MODE_DOWN_START = 3'd2,
        MODE_DOWN       = 3'd3,
        MODE_STOP_START = 3'd4,
        MODE_STOP       = 3'd5
    } t_mode;

    // per-channel state
    typedef struct packed {
        t_mode                        mode;
        logic [smrc_pkg::RunW-1:0]    run;
        logic [smrc_pkg::GuardW-1:0]  guard;
        logic                         pwr;
        logic                         dir;
    } t_chan;

    // one channel update: tick countdown, start action, then command rules
    function automatic t_chan chan_next(
        input t_chan                        c,
        input logic                         is_tick,
        input logic                         is_up,
        input logic                         is_down,
        input logic [smrc_pkg::GuardW-1:0]  delay,
        input logic [smrc_pkg::RunW-1:0]    run_time,
        input logic [smrc_pkg::TickW-1:0]   guard_ticks
    );
        t_chan n;
        t_mode m;
        n = c;
        if (is_tick) begin
            if (n.guard != '0) begin
                n.guard = n.guard - smrc_pkg::GuardW'(1);
            end else if (n.run != '0) begin
                n.run = n.run - smrc_pkg::RunW'(1);
                n.pwr = 1'b1;
            end else if (n.pwr) begin
                n.pwr   = 1'b0;
                n.dir   = 1'b0;
                n.guard = smrc_pkg::GuardW'(guard_ticks);
            end
        end
        m = n.mode;
        case (m)
            MODE_UP_START, MODE_DOWN_START: begin
                if (delay > n.guard) begin
                    n.guard = delay;
                end
                n.run  = run_time;
                n.dir  = (m == MODE_UP_START);
                n.mode = (m == MODE_UP_START) ? MODE_UP : MODE_DOWN;
                m      = n.mode;
            end
            MODE_STOP_START: begin
                n.dir = 1'b0;
                if (n.pwr) begin
                    n.pwr   = 1'b0;
                    n.guard = smrc_pkg::GuardW'(guard_ticks);
                end
                n.run  = '0;
                n.mode = MODE_STOP;
                m      = MODE_STOP;
            end
            default: begin
            end
        endcase
        case (m)
            MODE_UP: begin
                if (is_down) begin
                    n.mode = (n.run != '0) ? MODE_STOP_START : MODE_DOWN_START;
                end else if (is_up && n.run == '0) begin
                    n.mode = MODE_UP_START;
                end
            end
            MODE_DOWN: begin
                if (is_up) begin
                    n.mode = (n.run != '0) ? MODE_STOP_START : MODE_UP_START;
                end
            end
            default: begin
                if (is_up) begin
                    n.mode = MODE_UP_START;
                end else if (is_down) begin
                    n.mode = MODE_DOWN_START;
                end else begin
                    n.mode = MODE_STOP;
                end
            end
        endcase
        return n;
    endfunction

    // configuration registers
    logic [smrc_pkg::RunW-1:0]   r_run_time_long;
    logic [smrc_pkg::RunW-1:0]   r_run_time_short;
    logic [smrc_pkg::MaskW-1:0]  r_long_mask;
    logic [smrc_pkg::TickW-1:0]  r_guard_ticks;
    logic [smrc_pkg::TickW-1:0]  r_stagger_step;

    // input register
    logic                        r_in_full;
    logic [smrc_pkg::OpW-1:0]    r_op;
    logic [smrc_pkg::MaskW-1:0]  r_mask;

    // channel state and result valid
    t_chan                       r_chan [smrc_pkg::CHANNELS];
    t_chan                       n_chan [smrc_pkg::CHANNELS];
    logic                        r_out_valid;

    logic                        advance;
    logic                        take;
    logic [smrc_pkg::BitsW-1:0]  mask_ext;
    logic [smrc_pkg::BitsW-1:0]  long_ext;
    logic [smrc_pkg::BitsW-1:0]  power_ext;
    logic [smrc_pkg::BitsW-1:0]  dir_ext;

    // handshake: the input register moves on whenever the result slot frees
    assign advance     = r_in_full && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_full && !advance;
    assign take        = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_time_long  <= smrc_pkg::RST_RUN_TIME_LONG;
            r_run_time_short <= smrc_pkg::RST_RUN_TIME_SHORT;
            r_long_mask      <= smrc_pkg::RST_LONG_MASK;
            r_guard_ticks    <= smrc_pkg::RST_GUARD_TICKS;
            r_stagger_step   <= smrc_pkg::RST_STAGGER_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                smrc_pkg::CFG_RUN_TIME_LONG:  r_run_time_long  <= i_cfg_data;
                smrc_pkg::CFG_RUN_TIME_SHORT: r_run_time_short <= i_cfg_data;
                smrc_pkg::CFG_LONG_MASK:
                    r_long_mask <= i_cfg_data[smrc_pkg::MaskW-1:0];
                smrc_pkg::CFG_GUARD_TICKS:
                    r_guard_ticks <= i_cfg_data[smrc_pkg::TickW-1:0];
                smrc_pkg::CFG_STAGGER_STEP:
                    r_stagger_step <= i_cfg_data[smrc_pkg::TickW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full <= 1'b0;
        end else if (take) begin
            r_in_full <= 1'b1;
        end else if (advance) begin
            r_in_full <= 1'b0;
        end
        if (take) begin
            r_op   <= i_operation;
            r_mask <= i_channel_mask;
        end
    end

    // widen masks to the channel count
    assign mask_ext = smrc_pkg::BitsW'(r_mask);
    assign long_ext = smrc_pkg::BitsW'(r_long_mask);

    // per-channel next state, with the staggered start delay
    always_comb begin
        logic                        is_tick;
        logic                        is_up;
        logic                        is_down;
        logic                        sel;
        logic [smrc_pkg::BitsW-1:0]  below;
        logic [smrc_pkg::CountW-1:0] rank;
        logic [smrc_pkg::GuardW-1:0] delay;
        logic [smrc_pkg::RunW-1:0]   run_time;
        is_tick = (r_op == smrc_pkg::OP_TICK);
        is_up   = (r_op == smrc_pkg::OP_UP);
        is_down = (r_op == smrc_pkg::OP_DOWN);
        for (int ch = 0; ch < smrc_pkg::CHANNELS; ch++) begin
            below = '0;
            for (int j = 0; j < ch; j++) begin
                below[j] = mask_ext[j];
            end
            rank     = smrc_pkg::CountW'($countones(below));
            delay    = smrc_pkg::GuardW'(rank) * smrc_pkg::GuardW'(r_stagger_step);
            run_time = long_ext[ch] ? r_run_time_long : r_run_time_short;
            sel      = mask_ext[ch] && (is_up || is_down);
            if (is_tick) begin
                n_chan[ch] = chan_next(r_chan[ch], 1'b1, 1'b0, 1'b0, '0,
                                       run_time, r_guard_ticks);
            end else if (sel) begin
                n_chan[ch] = chan_next(r_chan[ch], 1'b0, is_up, is_down, delay,
                                       run_time, r_guard_ticks);
            end else begin
                n_chan[ch] = r_chan[ch];
            end
        end
    end

    // channel state, which also forms the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int ch = 0; ch < smrc_pkg::CHANNELS; ch++) begin
                r_chan[ch] <= '{mode: MODE_STOP, run: '0, guard: '0,
                                pwr: 1'b0, dir: 1'b0};
            end
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                for (int ch = 0; ch < smrc_pkg::CHANNELS; ch++) begin
                    r_chan[ch] <= n_chan[ch];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // relay masks
    always_comb begin
        power_ext = '0;
        dir_ext   = '0;
        for (int ch = 0; ch < smrc_pkg::CHANNELS; ch++) begin
            power_ext[ch] = r_chan[ch].pwr;
            dir_ext[ch]   = r_chan[ch].dir;
        end
    end

    assign o_power_mask     = power_ext[smrc_pkg::MaskW-1:0];
    assign o_direction_mask = dir_ext[smrc_pkg::MaskW-1:0];

endmodule

FILE: tb/smrc_tb_pkg.sv
// relay state predictor and result scoreboard for the shutter motor relay controller
package smrc_tb_pkg;
    import smrc_pkg::*;

    // spare operation code, the block leaves its state alone
    localparam logic [OpW-1:0] OP_SPARE = 2'd3;

    // per-channel motion mode
    typedef enum logic [2:0] {
        CH_UP_START   = 3'd0,
        CH_UP         = 3'd1,
        CH_DOWN_START = 3'd2,
        CH_DOWN       = 3'd3,
        CH_STOP_START = 3'd4,
        CH_STOP       = 3'd5
    } chan_mode_e;

    // relay masks after one item
    typedef struct packed {
        logic [MaskW-1:0] power;
        logic [MaskW-1:0] direction;
    } relay_masks_t;

    class relay_tracker;
        // settings copy
        logic [RunW-1:0]   run_long;
        logic [RunW-1:0]   run_short;
        logic [MaskW-1:0]  long_sel;
        logic [TickW-1:0]  guard_reload;
        logic [TickW-1:0]  stagger;

        // channel state copy
        chan_mode_e        mode [CHANNELS];
        logic [RunW-1:0]   run_left [CHANNELS];
        logic [GuardW-1:0] guard_left [CHANNELS];
        logic [BitsW-1:0]  power_now;
        logic [BitsW-1:0]  dir_now;

        // masks still to arrive, oldest first
        relay_masks_t      awaited_masks[$];
        int                mismatches;
        int                results_seen;

        function new();
            run_long     = RST_RUN_TIME_LONG;
            run_short    = RST_RUN_TIME_SHORT;
            long_sel     = RST_LONG_MASK;
            guard_reload = RST_GUARD_TICKS;
            stagger      = RST_STAGGER_STEP;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                mode[ch]       = CH_STOP;
                run_left[ch]   = '0;
                guard_left[ch] = '0;
            end
            power_now    = '0;
            dir_now      = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_config(logic [RunW-1:0] rl, logic [RunW-1:0] rs,
                                 logic [MaskW-1:0] ls, logic [TickW-1:0] gr,
                                 logic [TickW-1:0] st);
            run_long     = rl;
            run_short    = rs;
            long_sel     = ls;
            guard_reload = gr;
            stagger      = st;
        endfunction

        function int pending();
            return awaited_masks.size();
        endfunction

        // switch power off and rest the relays, only if power was on
        function void release_power(int ch);
            if (power_now[ch]) begin
                power_now[ch]  = 1'b0;
                dir_now[ch]    = 1'b0;
                guard_left[ch] = GuardW'(guard_reload);
            end
        endfunction

        function logic [RunW-1:0] run_length(int ch);
            if (ch < MaskW && long_sel[ch])
                return run_long;
            return run_short;
        endfunction

        // start action: guard at least the stagger delay, load run, set direction
        function void begin_run(int ch, logic [GuardW-1:0] delay, bit up);
            if (delay > guard_left[ch])
                guard_left[ch] = delay;
            run_left[ch] = run_length(ch);
            dir_now[ch]  = up;
            mode[ch]     = up ? CH_UP : CH_DOWN;
        endfunction

        function void advance_channel(int ch, logic [OpW-1:0] op, logic [GuardW-1:0] delay);
            chan_mode_e m;
            // tick countdown: guard first, then run with power on, then drop
            if (op == OP_TICK) begin
                if (guard_left[ch] != 0) begin
                    guard_left[ch] = guard_left[ch] - 1'b1;
                end else if (run_left[ch] != 0) begin
                    run_left[ch]  = run_left[ch] - 1'b1;
                    power_now[ch] = 1'b1;
                end else begin
                    release_power(ch);
                end
            end
            // pending start or stop action
            m = mode[ch];
            case (m)
                CH_UP_START: begin
                    begin_run(ch, delay, 1'b1);
                    m = CH_UP;
                end
                CH_DOWN_START: begin
                    begin_run(ch, delay, 1'b0);
                    m = CH_DOWN;
                end
                CH_STOP_START: begin
                    dir_now[ch] = 1'b0;
                    release_power(ch);
                    run_left[ch] = '0;
                    mode[ch]     = CH_STOP;
                    m            = CH_STOP;
                end
                default: ;
            endcase
            // command decides the next mode
            if (m == CH_UP) begin
                if (op == OP_DOWN)
                    mode[ch] = (run_left[ch] != 0) ? CH_STOP_START : CH_DOWN_START;
                else if (op == OP_UP && run_left[ch] == 0)
                    mode[ch] = CH_UP_START;
            end else if (m == CH_DOWN) begin
                if (op == OP_UP)
                    mode[ch] = (run_left[ch] != 0) ? CH_STOP_START : CH_UP_START;
            end else begin
                mode[ch] = CH_STOP;
                if (op == OP_UP)
                    mode[ch] = CH_UP_START;
                else if (op == OP_DOWN)
                    mode[ch] = CH_DOWN_START;
            end
        endfunction

        // accepted item: update the state copy and queue the masks it gives
        function void note_item(logic [OpW-1:0] op, logic [MaskW-1:0] sel);
            logic [GuardW-1:0] delay;
            relay_masks_t      masks;
            delay = '0;
            if (op == OP_TICK) begin
                for (int ch = 0; ch < CHANNELS; ch++)
                    advance_channel(ch, op, '0);
            end else if (op == OP_UP || op == OP_DOWN) begin
                for (int ch = 0; ch < CHANNELS && ch < MaskW; ch++) begin
                    if (sel[ch]) begin
                        advance_channel(ch, op, delay);
                        delay = delay + GuardW'(stagger);
                    end
                end
            end
            masks.power     = power_now[MaskW-1:0];
            masks.direction = dir_now[MaskW-1:0];
            awaited_masks.push_back(masks);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("mismatch at result %0d: %s", results_seen, what);
        endtask

        // accepted result against the oldest expectation
        task check_masks(logic [MaskW-1:0] power, logic [MaskW-1:0] direction);
            relay_masks_t want;
            results_seen++;
            if (awaited_masks.size() == 0) begin
                report($sformatf("unexpected result power=%h direction=%h", power, direction));
                return;
            end
            want = awaited_masks.pop_front();
            if (power !== want.power)
                report($sformatf("power %h, predicted %h", power, want.power));
            if (direction !== want.direction)
                report($sformatf("direction %h, predicted %h", direction, want.direction));
        endtask
    endclass

endpackage

FILE: tb/tb_top.sv
// top level testbench for the shutter motor relay controller
module tb_top;
    import smrc_pkg::*;
    import smrc_tb_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 147;
    localparam int QUIET_LIMIT = 1000;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [OpW-1:0]      i_operation    = OP_TICK;
    logic [MaskW-1:0]    i_channel_mask = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [MaskW-1:0]    o_power_mask;
    logic [MaskW-1:0]    o_direction_mask;
    logic                i_cfg_we       = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index    = CFG_RUN_TIME_LONG;
    logic [CfgDataW-1:0] i_cfg_data     = '0;

    relay_tracker tracker;
    int           calm_left    = 0;
    int           quiet_cycles = 0;

    shutter_motor_relay_control DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_channel_mask   (i_channel_mask),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_power_mask     (o_power_mask),
        .o_direction_mask (o_direction_mask),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock, period 4
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // one register write per cycle
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
    endtask

    // full set of settings, block idle
    task automatic write_settings(input logic [RunW-1:0] run_long, input logic [RunW-1:0] run_short,
                                  input logic [MaskW-1:0] long_sel,
                                  input logic [TickW-1:0] guard, input logic [TickW-1:0] stagger);
        write_reg(CFG_RUN_TIME_LONG, CfgDataW'(run_long));
        write_reg(CFG_RUN_TIME_SHORT, CfgDataW'(run_short));
        write_reg(CFG_LONG_MASK, CfgDataW'(long_sel));
        write_reg(CFG_GUARD_TICKS, CfgDataW'(guard));
        write_reg(CFG_STAGGER_STEP, CfgDataW'(stagger));
        i_cfg_we <= 1'b0;
        tracker.set_config(run_long, run_short, long_sel, guard, stagger);
    endtask

    // offer one item after a random gap, return at the falling edge after acceptance
    task automatic send_item(input logic [OpW-1:0] op, input logic [MaskW-1:0] sel);
        int gap;
        int r;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
            calm_left = $urandom_range(20, 60);
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_channel_mask <= sel;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.note_item(op, sel);
        @(negedge i_clk);
    endtask

    // receiver stall pattern: short and long stalls, stretches with none
    initial begin
        int stall_left;
        int free_left;
        int r;
        stall_left = 0;
        free_left  = 20;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && free_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    free_left = $urandom_range(20, 80);
                else if (r < 18)
                    stall_left = $urandom_range(8, 40);
                else if (r < 45)
                    stall_left = $urandom_range(1, 3);
                else
                    free_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                free_left--;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_masks(o_power_mask, o_direction_mask);
    end

    // watchdog on cycles with no item moving on either side
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial begin
        logic [OpW-1:0]   op;
        logic [MaskW-1:0] sel;
        int               r;
        tracker = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at reset settings: start, stagger, reverse while running,
        // repeated commands, empty masks, spare operation
        send_item(OP_UP, 10'h3FF);
        send_item(OP_UP, 10'h3FF);
        send_item(OP_TICK, 10'h000);
        send_item(OP_TICK, 10'h3FF);
        send_item(OP_DOWN, 10'h3FF);
        send_item(OP_DOWN, 10'h155);
        send_item(OP_TICK, 10'h2AA);
        send_item(OP_UP, 10'h2AA);
        send_item(OP_UP, 10'h000);
        send_item(OP_SPARE, 10'h3FF);
        send_item(OP_SPARE, 10'h000);
        send_item(OP_DOWN, 10'h200);
        send_item(OP_DOWN, 10'h200);
        send_item(OP_UP, 10'h001);
        send_item(OP_TICK, 10'h155);
        send_item(OP_DOWN, 10'h3FF);
        send_item(OP_TICK, 10'h000);
        send_item(OP_TICK, 10'h000);
        send_item(OP_UP, 10'h3FF);
        send_item(OP_TICK, 10'h000);

        // random phases, each with its own settings
        for (int phase = 0; phase < PHASES; phase++) begin
            i_in_valid <= 1'b0;
            while (tracker.pending() != 0) @(negedge i_clk);
            case (phase)
                0: write_settings(16'd5, 16'd3, 10'h3FF, 8'd0, 8'd0);
                1: write_settings(16'd0, 16'd0, 10'h000, 8'd255, 8'd255);
                2: write_settings(16'hFFFF, 16'hFFFF, 10'h155, 8'd2, 8'd1);
                3: write_settings(16'd12, 16'd7, 10'h2AA, 8'd3, 8'd2);
                5: write_settings(16'd1, 16'd2, MaskW'($urandom_range(0, 1023)), 8'd1, 8'd255);
                7: write_settings(16'd20, 16'd10, 10'd49, 8'd5, 8'd3);
                default: write_settings(RunW'($urandom_range(1, 40)), RunW'($urandom_range(0, 30)),
                                        MaskW'($urandom_range(0, 1023)),
                                        TickW'($urandom_range(0, 8)), TickW'($urandom_range(0, 6)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mostly ticks so that runs and guards play out
                r = $urandom_range(0, 99);
                if (r < 60)
                    op = OP_TICK;
                else if (r < 78)
                    op = OP_UP;
                else if (r < 95)
                    op = OP_DOWN;
                else
                    op = OP_SPARE;
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    sel = '0;
                    sel[$urandom_range(0, MaskW - 1)] = 1'b1;
                end else if (r < 50) begin
                    sel = '1;
                end else if (r < 55) begin
                    sel = '0;
                end else begin
                    sel = MaskW'($urandom_range(0, 1023));
                end
                send_item(op, sel);
            end
        end

        // drain and settle
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
